// File: src/bce_pkg.sv
// Shared types and constants for the battery charge estimator.
// Holds field widths, the voltage-to-charge curve and the range codes.
// Depends on nothing; every other file refers to it by scoped names.
package bce_pkg;

   // Field widths of the request and response words.
   localparam int unsigned SAMPLE_W   = 13;
   localparam int unsigned CHARGE_W   = 15;
   localparam int unsigned MEAN_W     = 13;
   localparam int unsigned SAMPLE_MAX = 8191;

   localparam int unsigned DEFAULT_GROUP_SIZE = 5;

   // Charge is reported in percent with eight fraction bits.
   localparam int unsigned Q8_SHIFT = 8;

   // Voltage-to-charge curve, millivolts against whole percent.
   localparam int unsigned SOC_POINTS = 12;
   localparam int unsigned SOC_SEGS   = SOC_POINTS - 1;
   localparam int unsigned SEG_W      = $clog2(SOC_SEGS);

   localparam int unsigned SOC_MV [SOC_POINTS] = '{
      3500, 3680, 3700, 3730, 3770, 3790, 3820, 3870, 3930, 4000, 4080, 4200
   };
   localparam int unsigned SOC_PCT [SOC_POINTS] = '{
      0, 9, 18, 27, 36, 45, 55, 64, 73, 82, 91, 100
   };

   // Widest segment of the curve and largest percent step between points.
   localparam int unsigned SOC_MAX_SPAN_MV  = 180;
   localparam int unsigned SOC_MAX_STEP_PCT = 10;
   localparam int unsigned STEP_W           = $clog2(SOC_MAX_STEP_PCT + 1);

   localparam logic [CHARGE_W-1:0] CHARGE_EMPTY =
      CHARGE_W'(SOC_PCT[0] << Q8_SHIFT);
   localparam logic [CHARGE_W-1:0] CHARGE_FULL =
      CHARGE_W'(SOC_PCT[SOC_POINTS-1] << Q8_SHIFT);

   // Where a group mean falls relative to the ends of the curve.
   typedef enum logic [1:0] {
      RANGE_LOW,
      RANGE_MID,
      RANGE_HIGH
   } range_type;

endpackage

// File: src/bce_req_if.sv
// Request channel of the battery charge estimator: one voltage sample per word.
// Uses bce_pkg for the sample width.
interface bce_req_if;
   logic                            valid;
   logic                            ready;
   logic [bce_pkg::SAMPLE_W-1:0]    sample_mv;

   modport source (output valid, output sample_mv, input ready);
   modport sink   (input valid, input sample_mv, output ready);
endinterface

// File: src/bce_rsp_if.sv
// Response channel of the battery charge estimator: charge and mean per word.
// Uses bce_pkg for the field widths.
interface bce_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bce_pkg::CHARGE_W-1:0]    charge_q8;
   logic [bce_pkg::MEAN_W-1:0]      mean_mv;

   modport source (output valid, output charge_q8, output mean_mv, input ready);
   modport sink   (input valid, input charge_q8, input mean_mv, output ready);
endinterface

// File: src/battery_charge_estimator.sv
// Battery charge estimator top level: sample accumulator and interpolation pipeline.
// Depends on bce_pkg (curve and widths) and the bce_req_if / bce_rsp_if channels.
// Configured at elaboration only, through GROUP_SIZE.

// Voltage samples in millivolts arrive one word per cycle and are summed in groups
// of GROUP_SIZE. The word that closes a group produces one response word holding
// the truncated group mean and a charge estimate in percent times 256: zero when
// the mean lies below 3500 mV, 25600 at or above 4200 mV, and otherwise a linear
// interpolation over a twelve-point curve, computed from the exact group sum so no
// precision is lost to the truncated mean. The block sustains one sample per clock
// cycle while stage one has room for each closing word. The closing word passes
// through four register stages (segment search, slope multiply, reciprocal
// multiply for the division by the segment width, and the final add) into the
// response register. Each stage holds its word while the one after it is full, so
// samples that do not close a group keep flowing in while a response waits to be
// taken, and a closing word is taken as long as the first stage has room.
module battery_charge_estimator #(
   parameter int unsigned GROUP_SIZE = bce_pkg::DEFAULT_GROUP_SIZE
) (
   input  logic       clock,
   input  logic       reset,
   bce_req_if.sink    req_if,
   bce_rsp_if.source  rsp_if
);

   // ---------------------------------------------------------------------------
   // Widths and constants derived from the group size.
   // ---------------------------------------------------------------------------
   localparam int unsigned SUM_W    = $clog2(GROUP_SIZE * bce_pkg::SAMPLE_MAX + 1);
   localparam int unsigned CNT_W    = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int unsigned SEG_W    = bce_pkg::SEG_W;
   localparam int unsigned SEGS     = bce_pkg::SOC_SEGS;
   localparam int unsigned STEP_W   = bce_pkg::STEP_W;
   localparam int unsigned CHARGE_W = bce_pkg::CHARGE_W;
   localparam int unsigned MEAN_W   = bce_pkg::MEAN_W;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_SIZE - 1);

   // The mean is sum / GROUP_SIZE, done as a multiply by a rounded-up reciprocal.
   // With the shift chosen this way the quotient is exact for every sum.
   localparam int unsigned MDIV_SH  = SUM_W + $clog2(GROUP_SIZE);
   localparam int unsigned MDIV_W   = MDIV_SH + 1;
   localparam logic [63:0] MDIV_K64 =
      ((64'd1 << MDIV_SH) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE);
   localparam int unsigned MPROD_W  = SUM_W + MDIV_W;
   localparam logic [MPROD_W-1:0] MDIV_K = MPROD_W'(MDIV_K64);

   // Offset into a segment, and offset times the percent step of that segment.
   localparam int unsigned OFF_W = $clog2(bce_pkg::SOC_MAX_SPAN_MV * GROUP_SIZE);
   localparam int unsigned X_W   =
      $clog2(bce_pkg::SOC_MAX_SPAN_MV * GROUP_SIZE * bce_pkg::SOC_MAX_STEP_PCT);

   // The segment division (x * 256) / (span * GROUP_SIZE) also uses a reciprocal,
   // one per segment. The dividend is below 2^(X_W+8) and every divisor below
   // 2^OFF_W, which makes the truncated quotient exact.
   localparam int unsigned RDIV_SH = X_W + bce_pkg::Q8_SHIFT + OFF_W;
   localparam int unsigned RDIV_W  = RDIV_SH + 1;
   localparam int unsigned RPROD_W = X_W + RDIV_W;
   localparam int unsigned FRAC_W  = bce_pkg::Q8_SHIFT + STEP_W;

   localparam logic [SUM_W-1:0] RANGE_LO_SUM =
      SUM_W'(bce_pkg::SOC_MV[0] * GROUP_SIZE);
   localparam logic [SUM_W-1:0] RANGE_HI_SUM =
      SUM_W'(bce_pkg::SOC_MV[bce_pkg::SOC_POINTS-1] * GROUP_SIZE);

   localparam logic [MEAN_W-1:0] MEAN_LO = MEAN_W'(bce_pkg::SOC_MV[0]);
   localparam logic [MEAN_W-1:0] MEAN_HI = MEAN_W'(bce_pkg::SOC_MV[bce_pkg::SOC_POINTS-1]);

   // ---------------------------------------------------------------------------
   // Per-segment constants: lower bound of the sum, percent step, base charge
   // and the reciprocal of the segment width in sum units.
   // ---------------------------------------------------------------------------
   logic [SUM_W-1:0]    seg_lo    [SEGS];
   logic [STEP_W-1:0]   seg_step  [SEGS];
   logic [CHARGE_W-1:0] seg_base  [SEGS];
   logic [RDIV_W-1:0]   seg_recip [SEGS];

   for (genvar k = 0; k < SEGS; k++) begin : g_seg
      localparam logic [63:0] DEN =
         64'((bce_pkg::SOC_MV[k+1] - bce_pkg::SOC_MV[k]) * GROUP_SIZE);
      localparam logic [63:0] RECIP = ((64'd1 << RDIV_SH) + DEN - 64'd1) / DEN;

      assign seg_lo[k]    = SUM_W'(bce_pkg::SOC_MV[k] * GROUP_SIZE);
      assign seg_step[k]  = STEP_W'(bce_pkg::SOC_PCT[k+1] - bce_pkg::SOC_PCT[k]);
      assign seg_base[k]  = CHARGE_W'(bce_pkg::SOC_PCT[k] << bce_pkg::Q8_SHIFT);
      assign seg_recip[k] = RDIV_W'(RECIP);
   end

   // ---------------------------------------------------------------------------
   // Pipeline flow control. A stage takes a new word when it is empty or when
   // its current word moves on in the same cycle.
   // ---------------------------------------------------------------------------
   logic rsp_vld_ff, rsp_vld_in;
   logic s1_vld_ff, s1_vld_in;
   logic s2_vld_ff, s2_vld_in;
   logic s3_vld_ff, s3_vld_in;
   logic s4_vld_ff, s4_vld_in;

   logic out_rdy, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
   logic s1_load, s2_load, s3_load, s4_load, out_load;

   assign out_rdy = !rsp_vld_ff || rsp_if.ready;
   assign s4_rdy  = !s4_vld_ff || out_rdy;
   assign s3_rdy  = !s3_vld_ff || s4_rdy;
   assign s2_rdy  = !s2_vld_ff || s3_rdy;
   assign s1_rdy  = !s1_vld_ff || s2_rdy;

   assign s2_load  = s1_vld_ff && s2_rdy;
   assign s3_load  = s2_vld_ff && s3_rdy;
   assign s4_load  = s3_vld_ff && s4_rdy;
   assign out_load = s4_vld_ff && out_rdy;

   // ---------------------------------------------------------------------------
   // Accumulator. Only the word that closes a group needs room in stage one.
   // ---------------------------------------------------------------------------
   logic [SUM_W-1:0] sum_ff, sum_in, sum_acc;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             grp_last;
   logic             req_acc;

   assign grp_last      = (cnt_ff == CNT_LAST);
   assign req_if.ready  = !grp_last || s1_rdy;
   assign req_acc       = req_if.valid && req_if.ready;
   assign sum_acc       = sum_ff + SUM_W'(req_if.sample_mv);

   always_comb begin
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      s1_load = 1'b0;
      if (req_acc) begin
         if (grp_last) begin
            sum_in  = '0;
            cnt_in  = '0;
            s1_load = 1'b1;
         end else begin
            sum_in = sum_acc;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage one holds the group sum. Its logic classifies the sum against the
   // curve ends, picks the segment with parallel comparators, forms the offset
   // into the segment and starts the mean multiply.
   // ---------------------------------------------------------------------------
   logic [SUM_W-1:0] s1_sum_ff;

   bce_pkg::range_type s2_range_in, s2_range_ff;
   logic [SEG_W-1:0]   s2_seg_in, s2_seg_ff;
   logic [OFF_W-1:0]   s2_off_in, s2_off_ff;
   logic [MPROD_W-1:0] s2_mprod_in, s2_mprod_ff;

   always_comb begin
      if (s1_sum_ff < RANGE_LO_SUM) begin
         s2_range_in = bce_pkg::RANGE_LOW;
      end else if (s1_sum_ff >= RANGE_HI_SUM) begin
         s2_range_in = bce_pkg::RANGE_HIGH;
      end else begin
         s2_range_in = bce_pkg::RANGE_MID;
      end

      // The highest interior point not above the sum opens the segment.
      s2_seg_in = '0;
      for (int k = 1; k < SEGS; k++) begin
         if (s1_sum_ff >= seg_lo[k]) begin
            s2_seg_in = SEG_W'(k);
         end
      end

      // Outside the curve the offset wraps, but the charge is forced then.
      s2_off_in   = OFF_W'(s1_sum_ff - seg_lo[s2_seg_in]);
      s2_mprod_in = MPROD_W'(s1_sum_ff) * MDIV_K;
   end

   // ---------------------------------------------------------------------------
   // Stage two scales the offset by the segment's percent step and finishes
   // the mean by dropping the reciprocal's fraction bits.
   // ---------------------------------------------------------------------------
   bce_pkg::range_type s3_range_ff;
   logic [SEG_W-1:0]   s3_seg_ff;
   logic [X_W-1:0]     s3_x_in, s3_x_ff;
   logic [MEAN_W-1:0]  s3_mean_in, s3_mean_ff;

   assign s3_x_in    = X_W'(s2_off_ff) * X_W'(seg_step[s2_seg_ff]);
   assign s3_mean_in = MEAN_W'(s2_mprod_ff >> MDIV_SH);

   // ---------------------------------------------------------------------------
   // Stage three multiplies by the segment reciprocal.
   // ---------------------------------------------------------------------------
   bce_pkg::range_type s4_range_ff;
   logic [SEG_W-1:0]   s4_seg_ff;
   logic [RPROD_W-1:0] s4_prod_in, s4_prod_ff;
   logic [MEAN_W-1:0]  s4_mean_ff;

   assign s4_prod_in = RPROD_W'(s3_x_ff) * RPROD_W'(seg_recip[s3_seg_ff]);

   // ---------------------------------------------------------------------------
   // Stage four takes the interpolated fraction, adds the segment's base charge
   // and applies the clamps at both ends of the curve.
   // ---------------------------------------------------------------------------
   logic [FRAC_W-1:0]   frac;
   logic [CHARGE_W-1:0] rsp_charge_in, rsp_charge_ff;
   logic [MEAN_W-1:0]   rsp_mean_ff;

   assign frac = FRAC_W'(s4_prod_ff >> (RDIV_SH - bce_pkg::Q8_SHIFT));

   always_comb begin
      unique case (s4_range_ff)
         bce_pkg::RANGE_LOW:  rsp_charge_in = bce_pkg::CHARGE_EMPTY;
         bce_pkg::RANGE_HIGH: rsp_charge_in = bce_pkg::CHARGE_FULL;
         bce_pkg::RANGE_MID:  rsp_charge_in = seg_base[s4_seg_ff] + CHARGE_W'(frac);
         default:             rsp_charge_in = bce_pkg::CHARGE_EMPTY;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Valid bits.
   // ---------------------------------------------------------------------------
   assign s1_vld_in  = s1_load  || (s1_vld_ff  && !s2_rdy);
   assign s2_vld_in  = s2_load  || (s2_vld_ff  && !s3_rdy);
   assign s3_vld_in  = s3_load  || (s3_vld_ff  && !s4_rdy);
   assign s4_vld_in  = s4_load  || (s4_vld_ff  && !out_rdy);
   assign rsp_vld_in = out_load || (rsp_vld_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         cnt_ff     <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         sum_ff     <= sum_in;
         cnt_ff     <= cnt_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         s3_vld_ff  <= s3_vld_in;
         s4_vld_ff  <= s4_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers load only when their stage takes a word.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sum_ff <= sum_acc;
      end
      if (s2_load) begin
         s2_range_ff <= s2_range_in;
         s2_seg_ff   <= s2_seg_in;
         s2_off_ff   <= s2_off_in;
         s2_mprod_ff <= s2_mprod_in;
      end
      if (s3_load) begin
         s3_range_ff <= s2_range_ff;
         s3_seg_ff   <= s2_seg_ff;
         s3_x_ff     <= s3_x_in;
         s3_mean_ff  <= s3_mean_in;
      end
      if (s4_load) begin
         s4_range_ff <= s3_range_ff;
         s4_seg_ff   <= s3_seg_ff;
         s4_prod_ff  <= s4_prod_in;
         s4_mean_ff  <= s3_mean_ff;
      end
      if (out_load) begin
         rsp_charge_ff <= rsp_charge_in;
         rsp_mean_ff   <= s4_mean_ff;
      end
   end

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.charge_q8 = rsp_charge_ff;
   assign rsp_if.mean_mv   = rsp_mean_ff;

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------

   // The group counter never passes the last position of a group.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_LAST)
      else $error("group counter out of range");

   // Interpolation inside the curve always stays below full charge.
   a_mid_below_full: assert property (@(posedge clock) disable iff (reset)
      s4_vld_ff && (s4_range_ff == bce_pkg::RANGE_MID) |-> rsp_charge_in < bce_pkg::CHARGE_FULL)
      else $error("interpolated charge reached full scale");

   // Mean and charge come from separate paths; full charge goes with a high mean.
   a_full_matches_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> ((rsp_mean_ff >= MEAN_HI) == (rsp_charge_ff == bce_pkg::CHARGE_FULL)))
      else $error("full charge disagrees with group mean");

   // A mean below the curve gives an empty charge.
   a_low_mean_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && (rsp_mean_ff < MEAN_LO) |-> rsp_charge_ff == bce_pkg::CHARGE_EMPTY)
      else $error("low mean gave nonzero charge");

endmodule
